@@ src/tgc_pkg.sv @@
// ============================================================================
// tgc_pkg
// Shared types and constants for the touch gesture classifier: event codes,
// register indexes and the records passed between the top level and the
// sensing front end.
// ============================================================================
package tgc_pkg;

   // Fixed field widths
   localparam int unsigned CsrDataBits  = 16;
   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned LevelBits    = 16;
   localparam int unsigned FracBits     = 8;
   localparam int unsigned BaseBits     = LevelBits + FracBits;
   localparam int unsigned EventBits    = 3;

   // Event reported with each result item
   typedef enum logic [EventBits-1:0] {
      EV_NONE       = 3'd0,
      EV_TAP        = 3'd1,
      EV_DOUBLE_TAP = 3'd2,
      EV_LONG_HOLD  = 3'd3,
      EV_PETTING    = 3'd4
   } tgc_event_type;

   // Register indexes on the configuration port
   typedef enum logic [CsrIndexBits-1:0] {
      CSR_TRIGGER_RATIO   = 3'd0,
      CSR_TRIGGER_DELTA   = 3'd1,
      CSR_BASELINE_ALPHA  = 3'd2,
      CSR_TAP_MAX_MS      = 3'd3,
      CSR_DOUBLE_TAP_WIN  = 3'd4,
      CSR_LONG_HOLD_MS    = 3'd5,
      CSR_PET_MIN_MS      = 3'd6,
      CSR_PET_MAX_MS      = 3'd7
   } tgc_csr_type;

   // Register reset values
   localparam logic [CsrDataBits-1:0] RstTriggerRatio  = 16'd55706;
   localparam logic [CsrDataBits-1:0] RstTriggerDelta  = 16'd30;
   localparam logic [CsrDataBits-1:0] RstBaselineAlpha = 16'd66;
   localparam logic [CsrDataBits-1:0] RstTapMaxMs      = 16'd300;
   localparam logic [CsrDataBits-1:0] RstDoubleTapWin  = 16'd400;
   localparam logic [CsrDataBits-1:0] RstLongHoldMs    = 16'd1500;
   localparam logic [CsrDataBits-1:0] RstPetMinMs      = 16'd600;
   localparam logic [CsrDataBits-1:0] RstPetMaxMs      = 16'd1400;

   // Settings used by the sensing front end
   typedef struct packed {
      logic [CsrDataBits-1:0] trigger_ratio;
      logic [CsrDataBits-1:0] trigger_delta;
      logic [CsrDataBits-1:0] baseline_alpha;
   } tgc_sense_cfg_type;

   // What the sensing front end reports for one poll
   typedef struct packed {
      logic                touch_now;
      logic [BaseBits-1:0] baseline_next;
   } tgc_sense_type;

endpackage

@@ src/touch_gesture_classifier_top.sv @@
// ============================================================================
// touch_gesture_classifier_top
// Capacitive touch poll classifier: baseline tracking, touch detection and
// tap / double tap / long hold / petting events.
// ============================================================================
// Usage:
//   Each req_ item is one sensor poll: three raw samples and a millisecond
//   timestamp. Each poll gives exactly one rsp_ item with the event of that
//   poll, the touch state, press and release pulses, the baseline level and
//   the hold duration.
//   A poll accepted into the input register waits there until the result
//   register can take it; then the median, touch test, baseline update and
//   gesture decision load the result register, where the tracking state is
//   updated too, and the result item leaves once the receiver does not stall.
//   Throughput is one poll per cycle while rsp_stall stays low.
//   When the receiver raises rsp_stall the result register holds its item;
//   one more poll waits in the input register, and only then does req_stall
//   rise. No poll is dropped.
//   The csr_ port is always ready. Write it only while no poll is in flight.
//   Reset (synchronous, active high) loads the register defaults, sets the
//   baseline to BASELINE_START, clears touch and tap tracking and empties
//   both pipeline registers.
// ============================================================================
module touch_gesture_classifier_top
   import tgc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS    = 16,
   parameter int unsigned TIME_BITS      = 32,
   parameter int unsigned TAP_MIN_MS     = 50,
   parameter int unsigned BASELINE_START = 1000
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_sample_first,
   input  logic [SAMPLE_BITS-1:0]  req_sample_second,
   input  logic [SAMPLE_BITS-1:0]  req_sample_third,
   input  logic [TIME_BITS-1:0]    req_now_ms,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [EventBits-1:0]    rsp_event_code,
   output logic                    rsp_is_touched,
   output logic                    rsp_press_pulse,
   output logic                    rsp_release_pulse,
   output logic [LevelBits-1:0]    rsp_baseline_level,
   output logic [TIME_BITS-1:0]    rsp_hold_duration_ms,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_data
);

   localparam logic [BaseBits-1:0]  BaseReset = BaseBits'(BASELINE_START << FracBits);
   localparam logic [TIME_BITS-1:0] TapMin    = TIME_BITS'(TAP_MIN_MS);

   // Configuration registers
   logic [CsrDataBits-1:0] trigger_ratio_ff, trigger_delta_ff, baseline_alpha_ff;
   logic [CsrDataBits-1:0] tap_max_ms_ff, double_tap_win_ff, long_hold_ms_ff;
   logic [CsrDataBits-1:0] pet_min_ms_ff, pet_max_ms_ff;

   // Input register
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_a_ff, in_sample_b_ff, in_sample_c_ff;
   logic [TIME_BITS-1:0]   in_now_ff;

   // Tracking state
   logic [BaseBits-1:0]  baseline_ff, baseline_in;
   logic                 active_ff, active_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 hold_fired_ff, hold_fired_in;
   logic                 pet_fired_ff, pet_fired_in;
   logic                 awaiting_ff, awaiting_in;
   logic [TIME_BITS-1:0] first_tap_ff, first_tap_in;

   // Result register
   logic                 out_valid_ff;
   tgc_event_type        out_event_ff, out_event_in;
   logic                 out_touched_ff;
   logic                 out_press_ff, out_press_in;
   logic                 out_release_ff, out_release_in;
   logic [LevelBits-1:0] out_level_ff;
   logic [TIME_BITS-1:0] out_hold_ff, out_hold_in;

   logic                 out_advance;
   logic                 step_go;
   tgc_sense_cfg_type    sense_cfg;
   tgc_sense_type        sense;
   logic [TIME_BITS-1:0] dur;
   logic [TIME_BITS-1:0] since_first;
   logic [TIME_BITS-1:0] tap_max, dtap_win, hold_limit, pet_min, pet_max;

   // Pipeline handshake
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign step_go     = in_valid_ff && out_advance;
   assign req_stall   = in_valid_ff && !out_advance;
   assign csr_ready   = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ratio_ff  <= RstTriggerRatio;
         trigger_delta_ff  <= RstTriggerDelta;
         baseline_alpha_ff <= RstBaselineAlpha;
         tap_max_ms_ff     <= RstTapMaxMs;
         double_tap_win_ff <= RstDoubleTapWin;
         long_hold_ms_ff   <= RstLongHoldMs;
         pet_min_ms_ff     <= RstPetMinMs;
         pet_max_ms_ff     <= RstPetMaxMs;
      end else if (csr_valid && csr_ready) begin
         case (tgc_csr_type'(csr_index))
            CSR_TRIGGER_RATIO:  trigger_ratio_ff  <= csr_data;
            CSR_TRIGGER_DELTA:  trigger_delta_ff  <= csr_data;
            CSR_BASELINE_ALPHA: baseline_alpha_ff <= csr_data;
            CSR_TAP_MAX_MS:     tap_max_ms_ff     <= csr_data;
            CSR_DOUBLE_TAP_WIN: double_tap_win_ff <= csr_data;
            CSR_LONG_HOLD_MS:   long_hold_ms_ff   <= csr_data;
            CSR_PET_MIN_MS:     pet_min_ms_ff     <= csr_data;
            CSR_PET_MAX_MS:     pet_max_ms_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the poll
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_sample_a_ff <= req_sample_first;
         in_sample_b_ff <= req_sample_second;
         in_sample_c_ff <= req_sample_third;
         in_now_ff      <= req_now_ms;
      end
   end

   // Median, touch test and baseline tracking
   assign sense_cfg.trigger_ratio  = trigger_ratio_ff;
   assign sense_cfg.trigger_delta  = trigger_delta_ff;
   assign sense_cfg.baseline_alpha = baseline_alpha_ff;

   tgc_sense #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sense (
      .sample_a (in_sample_a_ff),
      .sample_b (in_sample_b_ff),
      .sample_c (in_sample_c_ff),
      .baseline (baseline_ff),
      .cfg      (sense_cfg),
      .sense    (sense)
   );

   // Durations modulo the time width, thresholds widened to it
   assign dur         = in_now_ff - start_ff;
   assign since_first = in_now_ff - first_tap_ff;
   assign tap_max     = TIME_BITS'(tap_max_ms_ff);
   assign dtap_win    = TIME_BITS'(double_tap_win_ff);
   assign hold_limit  = TIME_BITS'(long_hold_ms_ff);
   assign pet_min     = TIME_BITS'(pet_min_ms_ff);
   assign pet_max     = TIME_BITS'(pet_max_ms_ff);

   // Gesture decision for the poll in the input register
   always_comb begin
      baseline_in    = sense.baseline_next;
      active_in      = active_ff;
      start_in       = start_ff;
      hold_fired_in  = hold_fired_ff;
      pet_fired_in   = pet_fired_ff;
      awaiting_in    = awaiting_ff;
      first_tap_in   = first_tap_ff;
      out_event_in   = EV_NONE;
      out_press_in   = 1'b0;
      out_release_in = 1'b0;
      out_hold_in    = '0;

      // Expire a pending first tap into a plain tap
      if (awaiting_ff && since_first > dtap_win) begin
         awaiting_in  = 1'b0;
         out_event_in = EV_TAP;
      end

      if (sense.touch_now && !active_ff) begin
         // Press: start timing
         active_in     = 1'b1;
         out_press_in  = 1'b1;
         start_in      = in_now_ff;
         hold_fired_in = 1'b0;
         pet_fired_in  = 1'b0;
      end else if (!sense.touch_now && active_ff) begin
         // Release: maybe a tap or the second tap of a pair
         active_in      = 1'b0;
         out_release_in = 1'b1;
         if (!hold_fired_ff && !pet_fired_ff && dur >= TapMin && dur <= tap_max) begin
            if (awaiting_in && since_first <= dtap_win) begin
               awaiting_in  = 1'b0;
               out_event_in = EV_DOUBLE_TAP;
            end else begin
               awaiting_in  = 1'b1;
               first_tap_in = in_now_ff;
            end
         end
      end else if (sense.touch_now && active_ff) begin
         // Held: long hold first, then petting, each once
         out_hold_in = dur;
         if (!hold_fired_ff && dur >= hold_limit) begin
            hold_fired_in = 1'b1;
            awaiting_in   = 1'b0;
            out_event_in  = EV_LONG_HOLD;
         end else if (!pet_fired_ff && dur >= pet_min && dur <= pet_max) begin
            pet_fired_in = 1'b1;
            awaiting_in  = 1'b0;
            out_event_in = EV_PETTING;
         end
      end
   end

   // Advance tracking state as the poll moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= BaseReset;
         active_ff     <= 1'b0;
         start_ff      <= '0;
         hold_fired_ff <= 1'b0;
         pet_fired_ff  <= 1'b0;
         awaiting_ff   <= 1'b0;
         first_tap_ff  <= '0;
      end else if (step_go) begin
         baseline_ff   <= baseline_in;
         active_ff     <= active_in;
         start_ff      <= start_in;
         hold_fired_ff <= hold_fired_in;
         pet_fired_ff  <= pet_fired_in;
         awaiting_ff   <= awaiting_in;
         first_tap_ff  <= first_tap_in;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (step_go) begin
         out_event_ff   <= out_event_in;
         out_touched_ff <= active_in;
         out_press_ff   <= out_press_in;
         out_release_ff <= out_release_in;
         out_level_ff   <= baseline_in[BaseBits-1:FracBits];
         out_hold_ff    <= out_hold_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_event_code       = out_event_ff;
   assign rsp_is_touched       = out_touched_ff;
   assign rsp_press_pulse      = out_press_ff;
   assign rsp_release_pulse    = out_release_ff;
   assign rsp_baseline_level   = out_level_ff;
   assign rsp_hold_duration_ms = out_hold_ff;

endmodule

@@ src/tgc_sense.sv @@
// ============================================================================
// tgc_sense
// Sensing front end: median of three samples, touch test against the
// baseline, and the first-order baseline tracking update (Q16.8 baseline,
// Q0.16 weight, round half up).
// ============================================================================
module tgc_sense
   import tgc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic [SAMPLE_BITS-1:0] sample_a,
   input  logic [SAMPLE_BITS-1:0] sample_b,
   input  logic [SAMPLE_BITS-1:0] sample_c,
   input  logic [BaseBits-1:0]    baseline,
   input  tgc_sense_cfg_type      cfg,
   output tgc_sense_type          sense
);

   logic [SAMPLE_BITS-1:0] median;
   logic [LevelBits-1:0]   raw;
   logic [BaseBits-1:0]    raw_fx;
   logic [39:0]            ratio_prod;
   logic                   ratio_hit;
   logic                   delta_hit;
   logic signed [24:0]     diff;
   logic signed [41:0]     weighted;
   logic signed [41:0]     rounded;
   logic signed [25:0]     step;
   logic signed [25:0]     tracked;

   // Pick the median of the three samples
   always_comb begin
      if ((sample_a >= sample_b && sample_a <= sample_c) ||
          (sample_a >= sample_c && sample_a <= sample_b)) begin
         median = sample_a;
      end else if ((sample_b >= sample_a && sample_b <= sample_c) ||
                   (sample_b >= sample_c && sample_b <= sample_a)) begin
         median = sample_b;
      end else begin
         median = sample_c;
      end
   end

   assign raw    = LevelBits'(median);
   assign raw_fx = {raw, {FracBits{1'b0}}};

   // Touch when the median sits below baseline times ratio, or far enough below
   assign ratio_prod = 40'(baseline) * 40'(cfg.trigger_ratio);
   assign ratio_hit  = {raw, 24'h000000} < ratio_prod;
   assign delta_hit  = (baseline > raw_fx) &&
                       ((baseline - raw_fx) >= {cfg.trigger_delta, {FracBits{1'b0}}});

   // Track the baseline: base + round((median - base) * alpha / 2^16)
   assign diff     = $signed({1'b0, raw_fx}) - $signed({1'b0, baseline});
   assign weighted = 42'(diff) * 42'($signed({1'b0, cfg.baseline_alpha}));
   assign rounded  = weighted + 42'sd32768;
   assign step     = $signed(rounded[41:16]);
   assign tracked  = $signed({2'b00, baseline}) + step;

   always_comb begin
      sense.touch_now     = ratio_hit || delta_hit;
      sense.baseline_next = sense.touch_now ? baseline : tracked[BaseBits-1:0];
   end

endmodule

@@ verif/touch_gesture_classifier_tb.sv @@
// ============================================================================
// touch_gesture_classifier testbench
// Drives sensor polls through the classifier and checks every result item
// against a cycle-free predictor of baseline tracking, touch detection and
// gesture events. A short directed table comes first. Random gesture
// sequences follow under several register settings, with random idling and
// stalling on both channels.
// ============================================================================
module testbench;
   import tgc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASE_POLLS  = 165;
   localparam int unsigned PHASES       = 7;
   localparam int unsigned TAP_FLOOR_MS = 50;

   // One expected result item
   typedef struct packed {
      tgc_event_type          ev;
      logic                   touched;
      logic                   press;
      logic                   rel;
      logic [LevelBits-1:0]   level;
      logic [31:0]            hold;
   } poll_result_type;

   // One row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [15:0]            s1;
      logic [15:0]            s2;
      logic [15:0]            s3;
      logic [31:0]            now;
      logic                   typed;
      tgc_event_type          ev;
      logic                   touched;
      logic                   press;
      logic                   rel;
      logic [LevelBits-1:0]   level;
      logic [31:0]            hold;
   } poll_row_type;

   localparam int unsigned DIRECTED_ROWS = 25;
   localparam poll_row_type DIRECTED [DIRECTED_ROWS] = '{
      // idle at the reset baseline, then a touch too short to be a tap
      '{16'd1000, 16'd1000, 16'd1000, 32'd0, 1'b1, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd1000, 32'd0},
      '{16'd0, 16'd0, 16'd0, 32'd10, 1'b1, EV_NONE, 1'b1, 1'b1, 1'b0,
        16'd1000, 32'd0},
      '{16'd0, 16'd65535, 16'd0, 32'd20, 1'b1, EV_NONE, 1'b1, 1'b0, 1'b0,
        16'd1000, 32'd10},
      '{16'd1000, 16'd1000, 16'd1000, 32'd30, 1'b1, EV_NONE, 1'b0, 1'b0, 1'b1,
        16'd1000, 32'd0},
      // single tap of the shortest length, reported when the window expires
      '{16'd0, 16'd0, 16'd0, 32'd100, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd1000, 16'd1000, 16'd1000, 32'd150, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd1000, 16'd1000, 16'd1000, 32'd551, 1'b1, EV_TAP, 1'b0, 1'b0, 1'b0,
        16'd1000, 32'd0},
      // double tap, first tap of the longest length, samples out of order
      '{16'd900, 16'd65535, 16'd0, 32'd1000, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd1000, 16'd0, 16'd65535, 32'd1300, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd65535, 16'd0, 16'd900, 32'd1500, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd1000, 16'd1000, 16'd1000, 32'd1600, 1'b1, EV_DOUBLE_TAP, 1'b0, 1'b0,
        1'b1, 16'd1000, 32'd0},
      // petting, then long hold, then a release that is no tap
      '{16'd0, 16'd0, 16'd0, 32'd2000, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd0, 16'd0, 16'd0, 32'd2700, 1'b1, EV_PETTING, 1'b1, 1'b0, 1'b0,
        16'd1000, 32'd700},
      '{16'd0, 16'd0, 16'd0, 32'd3500, 1'b1, EV_LONG_HOLD, 1'b1, 1'b0, 1'b0,
        16'd1000, 32'd1500},
      '{16'd1000, 16'd1000, 16'd1000, 32'd3600, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      // pending tap expires in the step where long hold fires: hold wins
      '{16'd0, 16'd0, 16'd0, 32'd4000, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd1000, 16'd1000, 16'd1000, 32'd4100, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd0, 16'd0, 16'd0, 32'd4200, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd0, 16'd0, 16'd0, 32'd5700, 1'b1, EV_LONG_HOLD, 1'b1, 1'b0, 1'b0,
        16'd1000, 32'd1500},
      '{16'd1000, 16'd1000, 16'd1000, 32'd5800, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      // touch across the time wrap, then a tap that expires
      '{16'd0, 16'd0, 16'd0, 32'hFFFF_FFF0, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0},
      '{16'd0, 16'd0, 16'd0, 32'h0000_0040, 1'b1, EV_NONE, 1'b1, 1'b0, 1'b0,
        16'd1000, 32'd80},
      '{16'd1000, 16'd1000, 16'd1000, 32'h0000_0060, 1'b0, EV_NONE, 1'b0, 1'b0,
        1'b0, 16'd0, 32'd0},
      // full-scale samples pull the baseline up; then a touch by delta alone
      '{16'd65535, 16'd65535, 16'd65535, 32'h0000_0200, 1'b0, EV_NONE, 1'b0, 1'b0,
        1'b0, 16'd0, 32'd0},
      '{16'd960, 16'd960, 16'd960, 32'h0000_0300, 1'b0, EV_NONE, 1'b0, 1'b0, 1'b0,
        16'd0, 32'd0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [15:0]             req_sample_first;
   logic [15:0]             req_sample_second;
   logic [15:0]             req_sample_third;
   logic [31:0]             req_now_ms;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [EventBits-1:0]    rsp_event_code;
   logic                    rsp_is_touched;
   logic                    rsp_press_pulse;
   logic                    rsp_release_pulse;
   logic [LevelBits-1:0]    rsp_baseline_level;
   logic [31:0]             rsp_hold_duration_ms;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_data;

   // Predictor copy of the registers and tracking state
   logic [CsrDataBits-1:0]  settings [8];
   logic [BaseBits-1:0]     model_base;
   logic                    model_touch;
   logic [31:0]             model_start;
   logic                    model_hold_fired;
   logic                    model_pet_fired;
   logic                    model_waiting;
   logic [31:0]             model_first_tap;

   poll_result_type         pending[$];
   int unsigned             idle_pct;
   int unsigned             stall_pct;
   int unsigned             mismatches;
   int unsigned             checked;
   int unsigned             polls_sent;
   int unsigned             cycle_count;
   int unsigned             event_hits [5];

   touch_gesture_classifier_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_first     (req_sample_first),
      .req_sample_second    (req_sample_second),
      .req_sample_third     (req_sample_third),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_is_touched       (rsp_is_touched),
      .rsp_press_pulse      (rsp_press_pulse),
      .rsp_release_pulse    (rsp_release_pulse),
      .rsp_baseline_level   (rsp_baseline_level),
      .rsp_hold_duration_ms (rsp_hold_duration_ms),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items outstanding",
                  cycle_count, pending.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Advance the predictor by one poll and return the result item it causes
   function automatic poll_result_type classify_poll(input logic [15:0] a, b, c,
                                                     input logic [31:0] t);
      poll_result_type res;
      logic [15:0]  med;
      logic [63:0]  raw_fx;
      logic [63:0]  base;
      logic [63:0]  alpha;
      logic [63:0]  mix;
      logic [31:0]  dur;
      logic         touch_now;

      if ((a >= b && a <= c) || (a >= c && a <= b)) med = a;
      else if ((b >= a && b <= c) || (b >= c && b <= a)) med = b;
      else med = c;

      raw_fx = 64'(med) << 8;
      base   = 64'(model_base);
      alpha  = 64'(settings[CSR_BASELINE_ALPHA]);
      res    = '0;
      res.ev = EV_NONE;

      // Touch by ratio or by delta below the baseline
      touch_now = ((64'(med) << 24) < base * 64'(settings[CSR_TRIGGER_RATIO])) ||
                  (base > raw_fx &&
                   (base - raw_fx) >= (64'(settings[CSR_TRIGGER_DELTA]) << 8));

      // Track the baseline only while untouched, round half up
      if (!touch_now) begin
         mix = base * (64'd65536 - alpha) + raw_fx * alpha + 64'd32768;
         model_base = mix[16 +: BaseBits];
      end

      // Expire a pending first tap
      if (model_waiting &&
          (t - model_first_tap) > 32'(settings[CSR_DOUBLE_TAP_WIN])) begin
         model_waiting = 1'b0;
         res.ev = EV_TAP;
      end

      if (touch_now && !model_touch) begin
         model_touch      = 1'b1;
         res.press        = 1'b1;
         model_start      = t;
         model_hold_fired = 1'b0;
         model_pet_fired  = 1'b0;
      end else if (!touch_now && model_touch) begin
         dur         = t - model_start;
         model_touch = 1'b0;
         res.rel     = 1'b1;
         if (!model_hold_fired && !model_pet_fired && dur >= TAP_FLOOR_MS &&
             dur <= 32'(settings[CSR_TAP_MAX_MS])) begin
            if (model_waiting &&
                (t - model_first_tap) <= 32'(settings[CSR_DOUBLE_TAP_WIN])) begin
               model_waiting = 1'b0;
               res.ev = EV_DOUBLE_TAP;
            end else begin
               model_waiting   = 1'b1;
               model_first_tap = t;
            end
         end
      end else if (touch_now && model_touch) begin
         dur = t - model_start;
         if (!model_hold_fired && dur >= 32'(settings[CSR_LONG_HOLD_MS])) begin
            model_hold_fired = 1'b1;
            model_waiting    = 1'b0;
            res.ev           = EV_LONG_HOLD;
         end else if (!model_pet_fired && dur >= 32'(settings[CSR_PET_MIN_MS]) &&
                      dur <= 32'(settings[CSR_PET_MAX_MS])) begin
            model_pet_fired = 1'b1;
            model_waiting   = 1'b0;
            res.ev          = EV_PETTING;
         end
      end

      res.touched = model_touch;
      res.level   = model_base[FracBits +: LevelBits];
      res.hold    = model_touch ? (t - model_start) : 32'd0;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Check each accepted result item against the oldest expectation
   always @(posedge clock) begin
      poll_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $error("result item arrived with nothing expected");
            mismatches++;
         end else begin
            want = pending.pop_front();
            compare_field("event_code", 32'(want.ev), 32'(rsp_event_code));
            compare_field("is_touched", 32'(want.touched), 32'(rsp_is_touched));
            compare_field("press_pulse", 32'(want.press), 32'(rsp_press_pulse));
            compare_field("release_pulse", 32'(want.rel), 32'(rsp_release_pulse));
            compare_field("baseline_level", 32'(want.level), 32'(rsp_baseline_level));
            compare_field("hold_duration_ms", want.hold, rsp_hold_duration_ms);
            checked++;
            if (rsp_event_code <= EV_PETTING) event_hits[rsp_event_code]++;
         end
      end
   end

   // Offer one poll, idling first at random; return at the accepting edge
   task automatic send_poll(input logic [15:0] a, b, c, input logic [31:0] t);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_first  <= a;
      req_sample_second <= b;
      req_sample_third  <= c;
      req_now_ms        <= t;
      do @(posedge clock); while (req_stall);
      polls_sent++;
   endtask

   // Hold the sender until every expected item has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(input tgc_csr_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      settings[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic [15:0] ratio, delta, alpha, tap_max,
                                input logic [15:0] window, hold, pet_min, pet_max);
      write_setting(CSR_TRIGGER_RATIO, ratio);
      write_setting(CSR_TRIGGER_DELTA, delta);
      write_setting(CSR_BASELINE_ALPHA, alpha);
      write_setting(CSR_TAP_MAX_MS, tap_max);
      write_setting(CSR_DOUBLE_TAP_WIN, window);
      write_setting(CSR_LONG_HOLD_MS, hold);
      write_setting(CSR_PET_MIN_MS, pet_min);
      write_setting(CSR_PET_MAX_MS, pet_max);
   endtask

   initial begin
      poll_result_type want;
      logic [31:0]  gen_time;
      logic [15:0]  a, b, c;
      bit           finger_down;
      int           ms_left;
      int           step;
      int           lvl;
      int           val;
      int unsigned  roll;

      // Known values on every input before reset releases
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_first  = '0;
      req_sample_second = '0;
      req_sample_third  = '0;
      req_now_ms        = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_TRIGGER_RATIO;
      csr_data          = '0;
      idle_pct          = 28;
      stall_pct         = 28;
      polls_sent        = 0;

      settings[CSR_TRIGGER_RATIO]  = RstTriggerRatio;
      settings[CSR_TRIGGER_DELTA]  = RstTriggerDelta;
      settings[CSR_BASELINE_ALPHA] = RstBaselineAlpha;
      settings[CSR_TAP_MAX_MS]     = RstTapMaxMs;
      settings[CSR_DOUBLE_TAP_WIN] = RstDoubleTapWin;
      settings[CSR_LONG_HOLD_MS]   = RstLongHoldMs;
      settings[CSR_PET_MIN_MS]     = RstPetMinMs;
      settings[CSR_PET_MAX_MS]     = RstPetMaxMs;
      model_base       = BaseBits'(1000 << FracBits);
      model_touch      = 1'b0;
      model_start      = '0;
      model_hold_fired = 1'b0;
      model_pet_fired  = 1'b0;
      model_waiting    = 1'b0;
      model_first_tap  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table under the reset settings
      foreach (DIRECTED[i]) begin
         send_poll(DIRECTED[i].s1, DIRECTED[i].s2, DIRECTED[i].s3, DIRECTED[i].now);
         want = classify_poll(DIRECTED[i].s1, DIRECTED[i].s2, DIRECTED[i].s3,
                              DIRECTED[i].now);
         if (DIRECTED[i].typed) begin
            want.ev      = DIRECTED[i].ev;
            want.touched = DIRECTED[i].touched;
            want.press   = DIRECTED[i].press;
            want.rel     = DIRECTED[i].rel;
            want.level   = DIRECTED[i].level;
            want.hold    = DIRECTED[i].hold;
         end
         pending.push_back(want);
      end

      // Random gesture sequences, one register setting per phase
      gen_time    = 32'h0001_0000;
      finger_down = 1'b0;
      ms_left     = 200;
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0: load_settings(RstTriggerRatio, RstTriggerDelta, RstBaselineAlpha,
                             RstTapMaxMs, RstDoubleTapWin, RstLongHoldMs,
                             RstPetMinMs, RstPetMaxMs);
            1: load_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                             16'd0, 16'd0, 16'd0, 16'd0);
            // empty tap and petting windows, frozen baseline
            2: load_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
            6: load_settings(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                             16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                             16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                             16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
            default: load_settings(16'($urandom_range(62000, 50000)),
                                   16'($urandom_range(100, 10)),
                                   16'($urandom_range(4000, 100)),
                                   16'($urandom_range(400, 200)),
                                   16'($urandom_range(700, 200)),
                                   16'($urandom_range(2500, 1000)),
                                   16'($urandom_range(900, 400)),
                                   16'($urandom_range(1600, 900)));
         endcase

         // Long stretch with no idling on either side, starting near the wrap
         idle_pct  = (ph == 3) ? 0 : 28;
         stall_pct = (ph == 3) ? 0 : 28;
         if (ph == 3) gen_time = 32'hFFFF_F000;

         for (int n = 0; n < PHASE_POLLS; n++) begin
            if (ph == 4 && n == 80) drain_results();

            // Advance time, with an occasional jump anywhere
            step = $urandom_range(80, 5);
            if ($urandom_range(63) == 0) gen_time = $urandom();
            gen_time += 32'(step);

            // Toggle the finger when its current press or gap runs out
            if (ms_left <= step) begin
               finger_down = !finger_down;
               if (finger_down) begin
                  case ($urandom_range(3))
                     0: ms_left = $urandom_range(60, 10);
                     1: ms_left = $urandom_range(350, 50);
                     2: ms_left = $urandom_range(1500, 500);
                     default: ms_left = $urandom_range(3000, 1400);
                  endcase
               end else begin
                  ms_left = $urandom_range(700, 20);
               end
            end else begin
               ms_left -= step;
            end

            // Finger well below the baseline, or noise around it
            lvl = int'(model_base[FracBits +: LevelBits]);
            if (finger_down) begin
               val = $urandom_range(lvl / 2);
            end else begin
               val = lvl + int'($urandom_range(6)) - 3;
               if (val < 0) val = 0;
               if (val > 65535) val = 65535;
            end
            a = 16'(val);
            b = 16'(val);
            c = 16'(val);
            roll = $urandom_range(99);
            if (roll < 8) begin
               a = 16'($urandom_range(16'hFFFF));
               b = 16'($urandom_range(16'hFFFF));
               c = 16'($urandom_range(16'hFFFF));
            end else if (roll < 33) begin
               case ($urandom_range(2))
                  0: a = 16'($urandom_range(16'hFFFF));
                  1: b = 16'($urandom_range(16'hFFFF));
                  default: c = 16'($urandom_range(16'hFFFF));
               endcase
            end

            send_poll(a, b, c, gen_time);
            pending.push_back(classify_poll(a, b, c, gen_time));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("Checked %0d result items from %0d polls over %0d register settings",
               checked, polls_sent, PHASES + 1);
      $display("Events seen: %0d tap, %0d double tap, %0d long hold, %0d petting",
               event_hits[EV_TAP], event_hits[EV_DOUBLE_TAP],
               event_hits[EV_LONG_HOLD], event_hits[EV_PETTING]);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
